/* design/deq_pkg.sv */
package deq_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed widths of the transaction fields
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned COUNT_W = 5;

  // Operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_R = 2'd0,
    CMD_POP_L  = 2'd1,
    CMD_POP_R  = 2'd2
  } cmd_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PEEK,
    S_DONE
  } state_e;

  // Input transaction
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] push_value;
  } deq_in_t;

  // Result transaction
  typedef struct packed {
    logic [WORD_W-1:0]  popped_value;
    logic               op_error;
    logic               is_empty;
    logic [COUNT_W-1:0] entry_count;
    logic [WORD_W-1:0]  left_value;
    logic [WORD_W-1:0]  right_value;
  } deq_res_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic peek;
    logic done;
  } deq_ctrl_t;

endpackage

/* design/deq_ctrl.sv */
module deq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output deq_pkg::deq_ctrl_t ctrl_o
);
  import deq_pkg::*;

  state_e state_q, state_d;

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: accept, execute, read both ends, report
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC:  state_d = S_PEEK;
      S_PEEK:  state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy        = 1'b1;
    ctrl_o      = '0;
    case (state_q)
      S_IDLE: begin
        busy        = 1'b0;
        ctrl_o.load = start;
      end
      S_EXEC:  ctrl_o.exec = 1'b1;
      S_PEEK:  ctrl_o.peek = 1'b1;
      S_DONE:  ctrl_o.done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

/* design/deq_dpath.sv */
module deq_dpath #(
  parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  deq_pkg::deq_ctrl_t ctrl_i,
  input  deq_pkg::deq_in_t   item_i,
  output logic               done_o,
  output deq_pkg::deq_res_t  result_o
);
  import deq_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0] DEPTH_S = (CW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // Wrapped index of the entry k places right of base
  function automatic logic [PW-1:0] slot(input logic [PW-1:0] base, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = {{(CW + 1 - PW){1'b0}}, base} + {1'b0, k};
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return s[PW-1:0];
  endfunction

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [CMD_W-1:0]      cmd_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [PW-1:0]         left_q, left_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  err_q, err_d;
  logic                  pop_ok_q, pop_ok_d;
  logic                  wr_en;
  logic [DATA_WIDTH-1:0] rd_a_q, rd_b_q, popped_q;
  logic [PW-1:0]         addr_a, addr_b, addr_wr, addr_left, addr_right;

  assign addr_left  = slot(left_q, '0);
  assign addr_right = slot(left_q, count_q - CW'(1));
  assign addr_wr    = slot(left_q, count_q);

  // Decode the operation against the current fill
  always_comb begin
    err_d    = 1'b0;
    pop_ok_d = 1'b0;
    wr_en    = 1'b0;
    left_d   = left_q;
    count_d  = count_q;
    addr_a   = addr_left;
    case (cmd_q)
      CMD_PUSH_R: begin
        if (count_q == DEPTH_C) begin
          err_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      CMD_POP_L: begin
        if (count_q == '0) begin
          err_d = 1'b1;
        end else begin
          pop_ok_d = 1'b1;
          left_d   = slot(left_q, CW'(1));
          count_d  = count_q - CW'(1);
        end
      end
      CMD_POP_R: begin
        addr_a = addr_right;
        if (count_q == '0) begin
          err_d = 1'b1;
        end else begin
          pop_ok_d = 1'b1;
          count_d  = count_q - CW'(1);
        end
      end
      default: err_d = 1'b1;
    endcase
    if (!ctrl_i.exec) addr_a = addr_left;
  end

  assign addr_b = addr_right;

  // Queue state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      count_q <= '0;
    end else if (ctrl_i.exec) begin
      left_q  <= left_d;
      count_q <= count_d;
    end
  end

  // Capture the transaction and the outcome of its operation
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= item_i.cmd;
      value_q <= DATA_WIDTH'(item_i.push_value);
    end
    if (ctrl_i.exec) begin
      err_q    <= err_d;
      pop_ok_q <= pop_ok_d;
    end
    if (ctrl_i.peek) begin
      popped_q <= pop_ok_q ? rd_a_q : '0;
    end
  end

  // Entry store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && wr_en) begin
      mem[addr_wr] <= value_q;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  // Build the result from the settled state
  always_comb begin
    result_o.popped_value = WORD_W'(popped_q);
    result_o.op_error     = err_q;
    result_o.is_empty     = (count_q == '0);
    result_o.entry_count  = COUNT_W'(count_q);
    result_o.left_value   = (count_q == '0) ? '0 : WORD_W'(rd_a_q);
    result_o.right_value  = (count_q == '0) ? '0 : WORD_W'(rd_b_q);
  end

  assign done_o = ctrl_i.done;

endmodule

/* design/double_ended_queue.sv */
// Double-ended queue of DEPTH words held in a ring buffer.
// Input channel: drive item_i and raise start; the transaction is taken at
// the rising edge where start is high and busy is low. item_i.cmd selects a
// push at the right end, a pop from the left end or a pop from the right end.
// Result channel: done_o is high for exactly one cycle while result_o holds
// the popped word, the error flag, the fill after the operation and the
// leftmost and rightmost words (zero when empty). The receiver cannot stall;
// a result must be taken in the cycle it is shown.
// Every transaction yields exactly one result. A push on a full queue, a pop
// on an empty queue and an unused command code set op_error and change nothing.
// After the accepting edge the block writes or reads the popped word, then
// reads both ends, then presents the result; busy drops again in the cycle
// after the result is shown. These steps are set by the registered reads of
// the entry store; no new transaction is taken until busy has dropped.
// Reset clears the pointers and the fill; the store itself is not cleared.
module double_ended_queue #(
  parameter int unsigned DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  deq_pkg::deq_in_t  item_i,
  output logic              done_o,
  output deq_pkg::deq_res_t result_o
);
  import deq_pkg::*;

  deq_ctrl_t ctrl;

  // Sequence each transaction
  deq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .ctrl_o (ctrl)
  );

  // Store, pointers and result
  deq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

/* sim/tb_double_ended_queue.sv */
`timescale 1ns / 1ps

module tb_double_ended_queue;
  import deq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0] DATA_MASK = (DATA_WIDTH_DEF >= WORD_W) ? {WORD_W{1'b1}} :
                                            WORD_W'((64'd1 << DATA_WIDTH_DEF) - 64'd1);
  localparam int unsigned RANDOM_ITEMS = 1600;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  deq_in_t   item_i;
  logic      done_o;
  deq_res_t  result_o;

  // Shadow copy of the deque contents
  logic [WORD_W-1:0] shadow_words [DEPTH_DEF];
  int unsigned       shadow_left;
  int unsigned       shadow_fill;

  deq_res_t    pending_results [$];
  int unsigned mismatch_count;
  int unsigned burst_left;
  int unsigned cycle_count;

  double_ended_queue dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Wrap an offset from the left end into the ring
  function automatic int unsigned ring_index(int unsigned offset);
    return (shadow_left + offset) % DEPTH_DEF;
  endfunction

  // Apply one command to the shadow deque and build the result it should give
  function automatic deq_res_t deque_predict(deq_in_t it);
    deq_res_t res;
    res = '0;
    case (it.cmd)
      CMD_PUSH_R: begin
        if (shadow_fill >= DEPTH_DEF) begin
          res.op_error = 1'b1;
        end else begin
          shadow_words[ring_index(shadow_fill)] = it.push_value & DATA_MASK;
          shadow_fill++;
        end
      end
      CMD_POP_L: begin
        if (shadow_fill == 0) begin
          res.op_error = 1'b1;
        end else begin
          res.popped_value = shadow_words[ring_index(0)];
          shadow_left = ring_index(1);
          shadow_fill--;
        end
      end
      CMD_POP_R: begin
        if (shadow_fill == 0) begin
          res.op_error = 1'b1;
        end else begin
          res.popped_value = shadow_words[ring_index(shadow_fill - 1)];
          shadow_fill--;
        end
      end
      default: begin
        res.op_error = 1'b1;
      end
    endcase
    res.is_empty    = (shadow_fill == 0);
    res.entry_count = COUNT_W'(shadow_fill);
    if (shadow_fill != 0) begin
      res.left_value  = shadow_words[ring_index(0)];
      res.right_value = shadow_words[ring_index(shadow_fill - 1)];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    $display("%0t: MISMATCH %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Send one transaction; open a new burst after a random gap when the last one ran out
  task automatic send_item(input logic [CMD_W-1:0] op, input logic [WORD_W-1:0] value);
    deq_in_t     it;
    int unsigned gap;
    it.cmd        = op;
    it.push_value = value;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 8);
    end
    burst_left--;
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.insert(pending_results.size(), deque_predict(it));
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    deq_res_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, popped_value", result_o.popped_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (result_o.popped_value !== want.popped_value)
          report_mismatch("popped_value", result_o.popped_value, want.popped_value);
        if (result_o.op_error !== want.op_error)
          report_mismatch("op_error", WORD_W'(result_o.op_error), WORD_W'(want.op_error));
        if (result_o.is_empty !== want.is_empty)
          report_mismatch("is_empty", WORD_W'(result_o.is_empty), WORD_W'(want.is_empty));
        if (result_o.entry_count !== want.entry_count)
          report_mismatch("entry_count", WORD_W'(result_o.entry_count),
                          WORD_W'(want.entry_count));
        if (result_o.left_value !== want.left_value)
          report_mismatch("left_value", result_o.left_value, want.left_value);
        if (result_o.right_value !== want.right_value)
          report_mismatch("right_value", result_o.right_value, want.right_value);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("double_ended_queue verification failed");
      $finish;
    end
  end

  // Pops and an unused code on the empty queue
  task automatic test_empty_errors();
    send_item(CMD_POP_L, $urandom);
    send_item(CMD_POP_R, $urandom);
    send_item(CMD_UNUSED, $urandom);
  endtask

  // Fill to capacity with extreme and random words
  task automatic test_fill_extremes();
    send_item(CMD_PUSH_R, '0);
    send_item(CMD_PUSH_R, '1);
    send_item(CMD_PUSH_R, 32'hAAAA_AAAA);
    send_item(CMD_PUSH_R, 32'h5555_5555);
    repeat (DEPTH_DEF - 4) send_item(CMD_PUSH_R, $urandom);
  endtask

  // Push and unused code on the full queue
  task automatic test_full_errors();
    send_item(CMD_PUSH_R, $urandom);
    send_item(CMD_UNUSED, $urandom);
  endtask

  // Take from each end, then refill one slot
  task automatic test_both_end_pops();
    send_item(CMD_POP_L, $urandom);
    send_item(CMD_POP_R, $urandom);
    send_item(CMD_PUSH_R, $urandom);
  endtask

  // Alternate filling and draining phases so both ends wrap and hit full and empty
  task automatic test_random_traffic();
    int unsigned phase_left;
    int unsigned roll;
    bit          filling;
    logic [CMD_W-1:0]  op;
    logic [WORD_W-1:0] value;
    phase_left = 0;
    filling    = 1'b0;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        filling    = ~filling;
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3)
        op = CMD_UNUSED;
      else if (roll < (filling ? 73 : 28))
        op = CMD_PUSH_R;
      else
        op = $urandom_range(0, 1) ? CMD_POP_L : CMD_POP_R;
      case ($urandom_range(0, 7))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom;
      endcase
      send_item(op, value);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    item_i         = '0;
    shadow_left    = 0;
    shadow_fill    = 0;
    mismatch_count = 0;
    burst_left     = 0;
    cycle_count    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_errors();
    test_fill_extremes();
    test_full_errors();
    test_both_end_pops();
    test_random_traffic();
    start <= 1'b0;

    // Wait for every outstanding result, then let the block settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/deq_pkg.sv
design/deq_ctrl.sv
design/deq_dpath.sv
design/double_ended_queue.sv
sim/tb_double_ended_queue.sv
